/* sv/lss_pkg.sv */
package lss_pkg;

    localparam int ValW = 32;
    localparam int PosW = 6;

    localparam logic [2:0] CMD_PUSH   = 3'd0;
    localparam logic [2:0] CMD_POP    = 3'd1;
    localparam logic [2:0] CMD_PEEK   = 3'd2;
    localparam logic [2:0] CMD_SEARCH = 3'd3;
    localparam logic [2:0] CMD_DUMP   = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [2:0]             command;
        logic signed [ValW-1:0] operand;
    } cmd_t;

    typedef struct packed {
        logic [1:0]             status;
        logic signed [ValW-1:0] entry_value;
        logic [PosW-1:0]        position;
        logic                   last;
    } rsp_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_PUSH,
        OP_POP,
        OP_MARK,
        OP_ROT
    } cell_op_t;

    typedef struct packed {
        cell_op_t               op;
        logic                   dump;
        logic signed [ValW-1:0] key;
    } cell_ctl_t;

endpackage

/* sv/lss_cell.sv */
module lss_cell
    import lss_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CW    = 6
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cell_ctl_t              ctl,
    input  logic [CW-1:0]          count,
    input  logic signed [ValW-1:0] upper_val,
    input  logic signed [ValW-1:0] lower_val,
    input  logic                   lower_hit,
    input  logic signed [ValW-1:0] top_val,
    output logic signed [ValW-1:0] val,
    output logic                   hit
);

    logic signed [ValW-1:0] val_reg, val_next;
    logic                   hit_reg, hit_next;
    logic                   occupied;
    logic                   bottom;

    assign occupied = CW'(INDEX) < count;
    assign bottom   = CW'(INDEX + 1) == count;

    always_comb
    begin
        val_next = val_reg;
        hit_next = hit_reg;
        unique case (ctl.op)
            OP_PUSH:
            begin
                val_next = upper_val;
                hit_next = 1'b0;
            end
            OP_POP:
            begin
                val_next = lower_val;
                hit_next = 1'b0;
            end
            OP_MARK:
            begin
                hit_next = occupied && (ctl.dump || val_reg == ctl.key);
            end
            OP_ROT:
            begin
                // wrap the top entry round to the bottom of the occupied run
                if (bottom)
                begin
                    val_next = top_val;
                    hit_next = 1'b0;
                end
                else if (occupied)
                begin
                    val_next = lower_val;
                    hit_next = lower_hit;
                end
            end
            default:
            begin
                val_next = val_reg;
                hit_next = hit_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign val = val_reg;
    assign hit = hit_reg;

endmodule

/* sv/lifo_stack_with_search_unit.sv */
// Channel  Direction  Payload  Handshake
// cmd      in         cmd_t    cmd_valid / cmd_ready
// rsp      out        rsp_t    rsp_valid / rsp_ready
//
// Push, pop and peek each give one registered result; the stack is a chain of cells, cell 0 on top.
// Search and dump mark the matching cells in the command cycle; then the occupied cells rotate
// one place a cycle while rsp is free, a marked cell 0 is reported, and a closing step ends the walk.
// A stalled rsp holds the walk; cmd_ready is low while a walk runs or a result waits.
// Reset clears the fill count and match flags; cell contents stay undefined until pushed.
module lifo_stack_with_search_unit
    import lss_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] remain_reg, remain_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic          found_reg, found_next;
    logic          rsp_valid_reg, rsp_valid_next;
    rsp_t          rsp_reg, rsp_next;

    cell_ctl_t              ctl;
    logic signed [ValW-1:0] val_w [DEPTH];
    logic [DEPTH-1:0]       hit_w;
    logic                   out_free;
    logic                   accept;
    logic                   full;
    logic                   empty;
    logic                   more_hits;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign cmd_ready = (state_reg == S_IDLE) && out_free;
    assign accept    = cmd_valid && cmd_ready;
    assign full      = count_reg == CW'(DEPTH);
    assign empty     = count_reg == '0;
    assign more_hits = |hit_w[DEPTH-1:1];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic signed [ValW-1:0] up_v;
            logic signed [ValW-1:0] lo_v;
            logic                   lo_h;
            if (gi == 0)
            begin : g_top
                assign up_v = cmd.operand;
            end
            else
            begin : g_mid
                assign up_v = val_w[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_end
                assign lo_v = val_w[gi];
                assign lo_h = 1'b0;
            end
            else
            begin : g_inner
                assign lo_v = val_w[gi+1];
                assign lo_h = hit_w[gi+1];
            end
            lss_cell #(
                .INDEX (gi),
                .CW    (CW)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .count     (count_reg),
                .upper_val (up_v),
                .lower_val (lo_v),
                .lower_hit (lo_h),
                .top_val   (val_w[0]),
                .val       (val_w[gi]),
                .hit       (hit_w[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        remain_next    = remain_reg;
        pos_next       = pos_reg;
        found_next     = found_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        ctl.op         = OP_HOLD;
        ctl.dump       = cmd.command == CMD_DUMP;
        ctl.key        = cmd.operand;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rsp_next.status      = ST_OK;
                    rsp_next.entry_value = '0;
                    rsp_next.position    = '0;
                    rsp_next.last        = 1'b1;
                    unique case (cmd.command)
                        CMD_PUSH:
                        begin
                            rsp_valid_next = 1'b1;
                            if (full)
                            begin
                                rsp_next.status = ST_FULL;
                            end
                            else
                            begin
                                ctl.op     = OP_PUSH;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_POP, CMD_PEEK:
                        begin
                            rsp_valid_next = 1'b1;
                            if (empty)
                            begin
                                rsp_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                rsp_next.entry_value = val_w[0];
                                rsp_next.position    = PosW'(1);
                                if (cmd.command == CMD_POP)
                                begin
                                    ctl.op     = OP_POP;
                                    count_next = count_reg - 1'b1;
                                end
                            end
                        end
                        CMD_SEARCH, CMD_DUMP:
                        begin
                            if (empty)
                            begin
                                rsp_valid_next  = 1'b1;
                                rsp_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                ctl.op      = OP_MARK;
                                state_next  = S_WALK;
                                remain_next = count_reg;
                                pos_next    = CW'(1);
                                found_next  = 1'b0;
                            end
                        end
                        default:
                        begin
                            // unused codes: drop without a result
                            rsp_valid_next = 1'b0;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                if (out_free)
                begin
                    if (remain_reg == '0)
                    begin
                        state_next = S_IDLE;
                        if (!found_reg)
                        begin
                            rsp_valid_next       = 1'b1;
                            rsp_next.status      = ST_NOTFOUND;
                            rsp_next.entry_value = '0;
                            rsp_next.position    = '0;
                            rsp_next.last        = 1'b1;
                        end
                    end
                    else
                    begin
                        ctl.op      = OP_ROT;
                        remain_next = remain_reg - 1'b1;
                        pos_next    = pos_reg + 1'b1;
                        if (hit_w[0])
                        begin
                            found_next           = 1'b1;
                            rsp_valid_next       = 1'b1;
                            rsp_next.status      = ST_OK;
                            rsp_next.entry_value = val_w[0];
                            rsp_next.position    = PosW'(pos_reg);
                            rsp_next.last        = !more_hits;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            remain_reg    <= '0;
            pos_reg       <= '0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            pos_reg       <= pos_next;
            found_reg     <= found_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("fill count beyond depth");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (remain_reg <= count_reg))
        else $error("walk longer than stack");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.command == CMD_PUSH && !full)
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push did not grow stack");

    a_count_steady_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |=> $stable(count_reg))
        else $error("fill count moved during walk");

    a_idle_no_hits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK && remain_reg == '0) |-> (hit_w == '0))
        else $error("unreported match after walk");

endmodule

/* verif/lifo_stack_checker.sv */
`timescale 1ns / 100ps

module lifo_stack_checker
    import lss_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  logic cmd_ready,
    input  cmd_t cmd,
    input  logic rsp_valid,
    input  logic rsp_ready,
    input  rsp_t rsp,
    output int   fail_count,
    output int   outstanding,
    output int   checked
);

    logic signed [ValW-1:0] stack_words [DEPTH];
    int unsigned            depth_used = 0;
    rsp_t                   expected_rsp_q [$];
    int                     fails = 0;
    int                     seen = 0;

    function automatic rsp_t make_rsp(input logic [1:0] st, input logic signed [ValW-1:0] val,
                                      input int unsigned pos, input logic lst);
        rsp_t r;
        r.status      = st;
        r.entry_value = val;
        r.position    = pos[PosW-1:0];
        r.last        = lst;
        return r;
    endfunction

    // Work out every result a command causes and update the shadow stack.
    task automatic predict_stack_results(input cmd_t c);
        int unsigned n;
        int unsigned p;
        int unsigned last_hit;
        n        = depth_used;
        last_hit = 0;
        case (c.command)
            CMD_PUSH:
            begin
                if (n >= DEPTH)
                    expected_rsp_q.push_back(make_rsp(ST_FULL, '0, 0, 1'b1));
                else
                begin
                    stack_words[n] = c.operand;
                    depth_used     = n + 1;
                    expected_rsp_q.push_back(make_rsp(ST_OK, '0, 0, 1'b1));
                end
            end
            CMD_POP, CMD_PEEK:
            begin
                if (n == 0)
                    expected_rsp_q.push_back(make_rsp(ST_EMPTY, '0, 0, 1'b1));
                else
                begin
                    expected_rsp_q.push_back(make_rsp(ST_OK, stack_words[n-1], 1, 1'b1));
                    if (c.command == CMD_POP)
                        depth_used = n - 1;
                end
            end
            CMD_SEARCH:
            begin
                if (n == 0)
                    expected_rsp_q.push_back(make_rsp(ST_EMPTY, '0, 0, 1'b1));
                else
                begin
                    // find the deepest match first so its result can carry last
                    for (p = 1; p <= n; p++)
                        if (stack_words[n-p] == c.operand)
                            last_hit = p;
                    if (last_hit == 0)
                        expected_rsp_q.push_back(make_rsp(ST_NOTFOUND, '0, 0, 1'b1));
                    else
                        for (p = 1; p <= last_hit; p++)
                            if (stack_words[n-p] == c.operand)
                                expected_rsp_q.push_back(make_rsp(ST_OK, stack_words[n-p], p,
                                                                  p == last_hit));
                end
            end
            CMD_DUMP:
            begin
                if (n == 0)
                    expected_rsp_q.push_back(make_rsp(ST_EMPTY, '0, 0, 1'b1));
                else
                    for (p = 1; p <= n; p++)
                        expected_rsp_q.push_back(make_rsp(ST_OK, stack_words[n-p], p, p == n));
            end
            default:
            begin
                // unused codes leave the stack alone and give nothing back
            end
        endcase
    endtask

    always @(posedge clk)
    begin : watch
        rsp_t want;
        logic bad;
        if (!rst_n)
        begin
            depth_used = 0;
            expected_rsp_q.delete();
        end
        else
        begin
            // compare before predicting so a stray result is never masked
            if (rsp_valid && rsp_ready)
            begin
                seen++;
                if (expected_rsp_q.size() == 0)
                begin
                    $display("%0t: result with nothing expected: status %0d value %0d",
                             $time, rsp.status, rsp.entry_value);
                    $display("%0t: unexpected result pos %0d last %0b",
                             $time, rsp.position, rsp.last);
                    fails++;
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    bad  = 1'b0;
                    if (rsp.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, rsp.status);
                        bad = 1'b1;
                    end
                    if (rsp.entry_value !== want.entry_value)
                    begin
                        $display("%0t: entry_value expected %0d actual %0d", $time,
                                 want.entry_value, rsp.entry_value);
                        bad = 1'b1;
                    end
                    if (rsp.position !== want.position)
                    begin
                        $display("%0t: position expected %0d actual %0d", $time,
                                 want.position, rsp.position);
                        bad = 1'b1;
                    end
                    if (rsp.last !== want.last)
                    begin
                        $display("%0t: last expected %0b actual %0b", $time,
                                 want.last, rsp.last);
                        bad = 1'b1;
                    end
                    if (bad)
                        fails++;
                end
            end
            if (cmd_valid && cmd_ready)
                predict_stack_results(cmd);
        end
        fail_count  <= fails;
        outstanding <= expected_rsp_q.size();
        checked     <= seen;
    end

endmodule

/* verif/tb_lifo_stack_with_search_unit.sv */
`timescale 1ns / 100ps

module tb_lifo_stack_with_search_unit;
    import lss_pkg::*;

    localparam int         DEPTH          = 32;
    localparam int         RANDOM_ITEMS   = 370;
    localparam int         PHASES         = 4;
    localparam int         HOLD_CYCLES    = 300;
    localparam logic [2:0] CMD_UNUSED_LO  = 3'd5;
    localparam logic [2:0] CMD_UNUSED_HI  = 3'd7;

    logic clk = 1'b0;
    logic rst_n;
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    int fail_count;
    int outstanding;
    int checked;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_req      = 0;
    int hold_ack      = 0;
    int hold_left     = 0;
    int driven_items  = 0;
    int op_counts [8] = '{default: 0};

    int idle_plan  [PHASES] = '{0, 71, 0, 34};
    int stall_plan [PHASES] = '{0, 0, 71, 34};

    logic signed [ValW-1:0] value_pool [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                                               32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555,
                                               32'hAAAA_AAAA, 32'h0000_002A};

    always #5 clk = ~clk;

    lifo_stack_with_search_unit #(
        .DEPTH (DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    lifo_stack_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .checked     (checked)
    );

    // Result side: random stalls, or a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req != hold_ack)
        begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic logic signed [ValW-1:0] pick_value();
        if ($urandom_range(1) == 0)
            return value_pool[$urandom_range(7)];
        return $urandom();
    endfunction

    // Offer one command and hold it until the transfer; valid stays high on return.
    task automatic offer(input logic [2:0] op, input logic signed [ValW-1:0] val);
        cmd_t c;
        c.command = op;
        c.operand = val;
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        op_counts[op]++;
        if (op <= CMD_DUMP)
            driven_items++;
    endtask

    task automatic settle();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic random_command();
        int r;
        r = $urandom_range(99);
        if (r < 38)
            offer(CMD_PUSH, pick_value());
        else if (r < 55)
            offer(CMD_POP, $urandom());
        else if (r < 65)
            offer(CMD_PEEK, $urandom());
        else if (r < 85)
            offer(CMD_SEARCH, pick_value());
        else if (r < 93)
            offer(CMD_DUMP, $urandom());
        else
            offer(3'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO)), $urandom());
    endtask

    initial
    begin
        int base;
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd       <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty stack on every reading command
        offer(CMD_POP, 32'h1234_5678);
        offer(CMD_PEEK, 32'hFFFF_FFFF);
        offer(CMD_SEARCH, 32'h0000_0000);
        offer(CMD_DUMP, 32'h8000_0000);
        // extremes, with a repeated value for a multi-match search
        offer(CMD_PUSH, 32'h8000_0000);
        offer(CMD_PUSH, 32'h7FFF_FFFF);
        offer(CMD_PUSH, 32'h0000_0000);
        offer(CMD_PUSH, 32'hFFFF_FFFF);
        offer(CMD_PUSH, 32'h7FFF_FFFF);
        offer(CMD_PEEK, 32'h0000_0000);
        offer(CMD_SEARCH, 32'h7FFF_FFFF);
        offer(CMD_SEARCH, 32'h0000_0005);
        offer(CMD_SEARCH, 32'h8000_0000);
        offer(CMD_DUMP, 32'h0000_0000);
        offer(CMD_POP, 32'h0000_0000);
        offer(CMD_UNUSED_LO, 32'hFFFF_FFFF);
        offer(CMD_UNUSED_LO + 3'd1, 32'h0000_0000);
        offer(CMD_UNUSED_HI, 32'h8000_0000);
        repeat (5) offer(CMD_POP, $urandom());
        settle();
        base = driven_items;

        for (int ph = 0; ph < PHASES; ph++)
        begin
            send_idle_pct = idle_plan[ph];
            stall_pct     = stall_plan[ph];
            if (ph == 0)
                hold_req++;
            if (ph == 0 || ph == 3)
            begin
                // fill past the top, then walk the full stack
                repeat (DEPTH + 2) offer(CMD_PUSH, value_pool[$urandom_range(7)]);
                offer(CMD_SEARCH, value_pool[$urandom_range(7)]);
                offer(CMD_DUMP, $urandom());
            end
            if (ph == 2)
                repeat (DEPTH + 2) offer(CMD_POP, $urandom());
            while (driven_items < base + (ph + 1) * RANDOM_ITEMS / PHASES)
                random_command();
            settle();
        end

        repeat (2 * DEPTH + 8) @(posedge clk);
        $display("Commands: %0d push, %0d pop, %0d peek, %0d search, %0d dump",
                 op_counts[CMD_PUSH], op_counts[CMD_POP], op_counts[CMD_PEEK],
                 op_counts[CMD_SEARCH], op_counts[CMD_DUMP]);
        $display("%0d unused codes; %0d results checked over four idle/stall mixes",
                 op_counts[CMD_UNUSED_LO] + op_counts[CMD_UNUSED_LO + 3'd1]
                 + op_counts[CMD_UNUSED_HI], checked);
        $display("Covered full and empty stacks and a long result hold-off");
        if (fail_count == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
